FILE: rtl/sorted_pair_key_table_assert.svh
// Assertion macros shared by the RTL. Simulation gets the checks; synthesis
// gets empty bodies.
`ifndef SORTED_PAIR_KEY_TABLE_ASSERT_SVH
`define SORTED_PAIR_KEY_TABLE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define SPKT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted_pair_key_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SPKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted_pair_key_table: next-cycle check failed");

`else

`define SPKT_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPKT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/spkt_pkg.sv
package spkt_pkg;

   // Table geometry.
   localparam int CAPACITY     = 64;
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int ID_W         = 16;
   localparam int KEY_W        = 2 * ID_W;
   localparam int PAYLOAD_BITS = 32;

   // A lookup halves its window while it is wider than this, then scans.
   localparam int SCAN_SPAN = 4;

   // Input action codes.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // Result status codes.
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [ID_W-1:0]         id_first;
      logic [ID_W-1:0]         id_second;
      logic [PAYLOAD_BITS-1:0] entry_payload;
   } req_word_type;

   typedef struct packed {
      logic                    hit;
      logic [PAYLOAD_BITS-1:0] result_payload;
      logic                    status;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_W-1:0]        key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_LK_HALF,
      ST_LK_HCMP,
      ST_LK_SRD,
      ST_LK_SCMP
   } state_type;

   // Key of an identifier pair: smaller identifier in the upper half.
   function automatic logic [KEY_W-1:0] pair_key(input logic [ID_W-1:0] a,
                                                 input logic [ID_W-1:0] b);
      logic [KEY_W-1:0] k;
      if (a < b) begin
         k = {a, b};
      end else begin
         k = {b, a};
      end
      return k;
   endfunction

endpackage

FILE: rtl/sorted_pair_key_table.sv
// Channel   Ports                          Direction  Handshake
// request   start, req_word / busy         in / out   start && !busy
// response  rsp_strobe, rsp_word           out        rsp_strobe, one cycle
// config    csr_wr_en, csr_wr_data         in         csr_wr_en
//
// One word at a time through one entry memory with a write port and a registered read port;
// busy is high while a word is worked on, and its response comes in the cycle busy falls.
// Lookup: halves its window while it is wider than SCAN_SPAN, then scans the rest entry by entry.
// Insert: shifts each larger entry up one slot, then writes the new word into the hole or slot zero.
// A refused insert or a lookup in an empty table answers next cycle with busy kept low.
// Reset is synchronous and the table needs no clearing pass; the receiver cannot stall.
`include "sorted_pair_key_table_assert.svh"

module sorted_pair_key_table (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  spkt_pkg::req_word_type                 req_word,
   output logic                                   rsp_strobe,
   output spkt_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_wr_en,
   input  logic [spkt_pkg::PAYLOAD_BITS-1:0]      csr_wr_data
);

   // Sequencer state and control registers.
   spkt_pkg::state_type state_ff, state_in;
   logic [spkt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [spkt_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [spkt_pkg::CNT_W-1:0] lo_ff, lo_in;
   logic [spkt_pkg::CNT_W-1:0] hi_ff, hi_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;

   // Payload registers.
   logic [spkt_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [spkt_pkg::PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [spkt_pkg::PAYLOAD_BITS-1:0] default_ff, default_in;
   spkt_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   // Entry memory ports.
   spkt_pkg::entry_type       entry_mem [spkt_pkg::CAPACITY];
   spkt_pkg::entry_type       rd_word_ff;
   logic [spkt_pkg::IDX_W-1:0] rd_addr;
   logic [spkt_pkg::IDX_W-1:0] wr_addr;
   logic                       wr_en;
   spkt_pkg::entry_type        wr_word;

   // Shared compare unit and helpers.
   logic                       key_gt;
   logic                       key_eq;
   logic                       accept;
   logic                       wide_window;
   logic [spkt_pkg::CNT_W:0]   mid_sum;
   logic [spkt_pkg::CNT_W-1:0] mid;
   logic [spkt_pkg::CNT_W-1:0] last_idx;
   logic [spkt_pkg::CNT_W-1:0] scan_end;

   assign accept      = start && (state_ff == spkt_pkg::ST_IDLE);
   assign key_gt      = rd_word_ff.key > key_ff;
   assign key_eq      = rd_word_ff.key == key_ff;
   assign wide_window = (hi_ff - lo_ff) > spkt_pkg::CNT_W'(spkt_pkg::SCAN_SPAN);
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[spkt_pkg::CNT_W:1];
   assign last_idx    = count_ff - spkt_pkg::CNT_W'(1);
   assign scan_end    = ((hi_ff + spkt_pkg::CNT_W'(spkt_pkg::SCAN_SPAN)) > last_idx)
                        ? last_idx
                        : hi_ff + spkt_pkg::CNT_W'(spkt_pkg::SCAN_SPAN);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spkt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_word.action == spkt_pkg::ACT_INSERT) begin
                  if (count_ff != spkt_pkg::CNT_W'(spkt_pkg::CAPACITY)) begin
                     state_in = spkt_pkg::ST_INS_RD;
                  end
               end else if (count_ff != '0) begin
                  state_in = spkt_pkg::ST_LK_HALF;
               end
            end
         end
         spkt_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               state_in = spkt_pkg::ST_IDLE;
            end else begin
               state_in = spkt_pkg::ST_INS_CMP;
            end
         end
         spkt_pkg::ST_INS_CMP: begin
            if (key_gt) begin
               state_in = spkt_pkg::ST_INS_RD;
            end else begin
               state_in = spkt_pkg::ST_IDLE;
            end
         end
         spkt_pkg::ST_LK_HALF: begin
            if (wide_window) begin
               state_in = spkt_pkg::ST_LK_HCMP;
            end else begin
               state_in = spkt_pkg::ST_LK_SRD;
            end
         end
         spkt_pkg::ST_LK_HCMP: begin
            state_in = spkt_pkg::ST_LK_HALF;
         end
         spkt_pkg::ST_LK_SRD: begin
            if (idx_ff <= hi_ff) begin
               state_in = spkt_pkg::ST_LK_SCMP;
            end else begin
               state_in = spkt_pkg::ST_IDLE;
            end
         end
         spkt_pkg::ST_LK_SCMP: begin
            if (!key_gt && !key_eq) begin
               state_in = spkt_pkg::ST_LK_SRD;
            end else begin
               state_in = spkt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spkt_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, memory control and response per state.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      default_in    = csr_wr_en ? csr_wr_data : default_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rd_addr       = idx_ff[spkt_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[spkt_pkg::IDX_W-1:0];
      wr_word       = '{key: key_ff, payload: pay_ff};
      case (state_ff)
         spkt_pkg::ST_IDLE: begin
            if (accept) begin
               key_in = spkt_pkg::pair_key(req_word.id_first, req_word.id_second);
               pay_in = req_word.entry_payload;
               idx_in = count_ff;
               lo_in  = '0;
               hi_in  = last_idx;
               if (req_word.action == spkt_pkg::ACT_INSERT) begin
                  // Full table refuses at once.
                  if (count_ff == spkt_pkg::CNT_W'(spkt_pkg::CAPACITY)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in   = '{hit: 1'b0, result_payload: '0,
                                       status: spkt_pkg::STATUS_FULL};
                  end
               end else if (count_ff == '0) begin
                  // Empty table always misses.
                  rsp_strobe_in = 1'b1;
                  rsp_word_in   = '{hit: 1'b0, result_payload: default_ff,
                                    status: spkt_pkg::STATUS_DONE};
               end
            end
         end
         spkt_pkg::ST_INS_RD: begin
            // Fetch the entry below the hole, or place the new word at slot zero.
            rd_addr = idx_ff[spkt_pkg::IDX_W-1:0] - spkt_pkg::IDX_W'(1);
            if (idx_ff == '0) begin
               wr_en         = 1'b1;
               count_in      = count_ff + spkt_pkg::CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{hit: 1'b0, result_payload: '0,
                                 status: spkt_pkg::STATUS_DONE};
            end
         end
         spkt_pkg::ST_INS_CMP: begin
            // Larger keys move up one slot; otherwise the new word fills the hole.
            wr_en = 1'b1;
            if (key_gt) begin
               wr_word = rd_word_ff;
               idx_in  = idx_ff - spkt_pkg::CNT_W'(1);
            end else begin
               count_in      = count_ff + spkt_pkg::CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{hit: 1'b0, result_payload: '0,
                                 status: spkt_pkg::STATUS_DONE};
            end
         end
         spkt_pkg::ST_LK_HALF: begin
            // Probe the middle of a wide window, else set up the short scan.
            if (wide_window) begin
               rd_addr = mid[spkt_pkg::IDX_W-1:0];
               idx_in  = mid;
            end else begin
               hi_in  = scan_end;
               idx_in = lo_ff;
            end
         end
         spkt_pkg::ST_LK_HCMP: begin
            if (key_gt) begin
               hi_in = idx_ff;
            end else begin
               lo_in = idx_ff;
            end
         end
         spkt_pkg::ST_LK_SRD: begin
            if (idx_ff > hi_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{hit: 1'b0, result_payload: default_ff,
                                 status: spkt_pkg::STATUS_DONE};
            end
         end
         spkt_pkg::ST_LK_SCMP: begin
            if (key_eq) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{hit: 1'b1, result_payload: rd_word_ff.payload,
                                 status: spkt_pkg::STATUS_DONE};
            end else if (key_gt) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{hit: 1'b0, result_payload: default_ff,
                                 status: spkt_pkg::STATUS_DONE};
            end else begin
               idx_in = idx_ff + spkt_pkg::CNT_W'(1);
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spkt_pkg::ST_IDLE;
         count_ff      <= '0;
         default_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         default_ff    <= default_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working and response registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Entry memory: one write, one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_word;
      end
      rd_word_ff <= entry_mem[rd_addr];
   end

   assign busy       = state_ff != spkt_pkg::ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Checks.
   `SPKT_ASSERT_NEXT(a_full_refused, clock, reset,
      accept && req_word.action == spkt_pkg::ACT_INSERT &&
      count_ff == spkt_pkg::CNT_W'(spkt_pkg::CAPACITY),
      rsp_strobe && rsp_word.status == spkt_pkg::STATUS_FULL)
   `SPKT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= spkt_pkg::CNT_W'(spkt_pkg::CAPACITY))
   `SPKT_ASSERT_NOW(a_write_in_insert, clock, reset, wr_en,
      state_ff == spkt_pkg::ST_INS_RD || state_ff == spkt_pkg::ST_INS_CMP)
   `SPKT_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_strobe, !busy)

endmodule
